[hw/rtl/smacc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smacc_pkg
// Shared types, constants and arithmetic helpers of the stereo mix accumulator.
// ----------------------------------------------------------------------------
package smacc_pkg;

  localparam int BUF_FRAMES_DEF = 1024;
  localparam int POS_W          = 10;
  localparam int POS_EXT_W      = 17;
  localparam int SAMPLE_W       = 16;
  localparam int ACC_W          = 32;
  localparam int IN_TDATA_W     = 80;
  localparam int OUT_TDATA_W    = 32;
  localparam int SHIFT_16BIT    = 15;
  localparam int SHIFT_8BIT     = 7;
  localparam int RES_DEPTH      = 4;
  localparam int RES_PTR_W      = $clog2(RES_DEPTH);
  localparam int RES_CNT_W      = $clog2(RES_DEPTH + 1);

  localparam logic OP_MIX   = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

  typedef struct packed {
    logic [ACC_W-1:0] right;
    logic [ACC_W-1:0] left;
  } frame_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_right;
    logic signed [SAMPLE_W-1:0] out_left;
  } result_t;

  // sample * Q15 volume, floor shift by 7 or 15, low 32 bits
  function automatic logic [ACC_W-1:0] scale(input logic signed [SAMPLE_W-1:0] smp,
                                             input logic [SAMPLE_W-1:0] vol,
                                             input logic eight_bit);
    logic signed [32:0] s_ext;
    logic signed [32:0] v_ext;
    logic signed [32:0] prod;
    logic signed [32:0] shifted;
    s_ext   = {{17{smp[SAMPLE_W-1]}}, smp};
    v_ext   = {17'b0, vol};
    prod    = s_ext * v_ext;
    shifted = eight_bit ? (prod >>> SHIFT_8BIT) : (prod >>> SHIFT_16BIT);
    return shifted[ACC_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] saturate(input logic [ACC_W-1:0] w);
    logic in_range;
    in_range = (w[ACC_W-1:SAMPLE_W-1] == '0) || (w[ACC_W-1:SAMPLE_W-1] == '1);
    if (in_range) begin
      return w[SAMPLE_W-1:0];
    end else if (w[ACC_W-1]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

endpackage

[hw/rtl/smacc_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smacc_buffer
// Stereo accumulation memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module smacc_buffer #(
  parameter int DEPTH = smacc_pkg::BUF_FRAMES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  smacc_pkg::frame_t       wr_data,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  output smacc_pkg::frame_t       rd_data
);

  smacc_pkg::frame_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/smacc_result_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smacc_result_fifo
// Small queue of drained frames in front of the output stream.
// ----------------------------------------------------------------------------
module smacc_result_fifo (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  smacc_pkg::result_t                  push_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output smacc_pkg::result_t                  out_data,
  output logic [smacc_pkg::RES_CNT_W-1:0]     count
);

  smacc_pkg::result_t                 entries [smacc_pkg::RES_DEPTH];
  logic [smacc_pkg::RES_PTR_W-1:0]    wr_ptr;
  logic [smacc_pkg::RES_PTR_W-1:0]    rd_ptr;
  logic                               pop;

  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/stereo_mix_accumulator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_mix_accumulator_top
// Stereo 32-bit mix buffer: scaled accumulate and saturating drain.
// ----------------------------------------------------------------------------
// Takes one mix or drain transfer per clock while s_tready is high. After reset
// the buffer is swept to zero, one frame per cycle, with s_tready low. An
// item passes an input register (buffer read, volume multiply) and a result
// register (add or clear, write back, saturate); a drain result is offered on
// m_tdata once it has been written into the result queue. Back-to-back accesses
// to one frame are forwarded around the memory read-modify-write. A four-entry
// result queue absorbs output stalls; outside the clear sweep, s_tready drops
// only when that queue together with drains still in flight would overflow.
module stereo_mix_accumulator_top #(
  parameter int BUF_FRAMES = smacc_pkg::BUF_FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // frame_position[9:0], sample_left[25:10], sample_right[41:26],
  // is_eight_bit[42], is_mono[43], vol_left[59:44], vol_right[75:60], zero pad
  input  logic [79:0] s_tdata,
  // opcode[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_left[15:0], out_right[31:16]
  output logic [31:0] m_tdata
);

  localparam int AW = $clog2(BUF_FRAMES);
  localparam logic [smacc_pkg::POS_EXT_W-1:0] FRAMES_LIM =
    smacc_pkg::POS_EXT_W'(BUF_FRAMES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(BUF_FRAMES - 1);

  logic                                   accept;
  logic [smacc_pkg::POS_EXT_W-1:0]        pos_ext;
  logic                                   in_range;
  logic [AW-1:0]                          in_addr;

  logic                                   clearing;
  logic [AW-1:0]                          clr_addr;

  // input register
  logic                                   v1;
  logic                                   op1;
  logic                                   inr1;
  logic [AW-1:0]                          addr1;
  logic signed [smacc_pkg::SAMPLE_W-1:0]  sl1;
  logic signed [smacc_pkg::SAMPLE_W-1:0]  sr1;
  logic                                   eight1;
  logic                                   mono1;
  logic [smacc_pkg::SAMPLE_W-1:0]         vl1;
  logic [smacc_pkg::SAMPLE_W-1:0]         vr1;
  smacc_pkg::frame_t                      rd_data;
  smacc_pkg::frame_t                      base_next;
  smacc_pkg::frame_t                      delta_next;
  logic signed [smacc_pkg::SAMPLE_W-1:0]  sr_eff;

  // result register
  logic                                   v2;
  logic                                   op2;
  logic                                   inr2;
  logic [AW-1:0]                          addr2;
  smacc_pkg::frame_t                      base2;
  smacc_pkg::frame_t                      delta2;
  smacc_pkg::frame_t                      wr_val;
  logic                                   wr2;

  // last committed write
  logic                                   lw_v;
  logic [AW-1:0]                          lw_addr;
  smacc_pkg::frame_t                      lw_data;

  logic                                   mem_we;
  logic [AW-1:0]                          mem_waddr;
  smacc_pkg::frame_t                      mem_wdata;

  logic                                   push;
  smacc_pkg::result_t                     push_data;
  logic [smacc_pkg::RES_CNT_W-1:0]        res_count;
  logic [1:0]                             pend;
  logic [smacc_pkg::RES_CNT_W-1:0]        occupancy;

  assign pos_ext  = {{(smacc_pkg::POS_EXT_W - smacc_pkg::POS_W){1'b0}}, s_tdata[9:0]};
  assign in_range = pos_ext < FRAMES_LIM;
  assign in_addr  = AW'(pos_ext);
  assign accept   = s_tvalid && s_tready;

  assign pend      = {1'b0, v1 && (op1 == smacc_pkg::OP_DRAIN)} +
                     {1'b0, v2 && (op2 == smacc_pkg::OP_DRAIN)};
  assign occupancy = res_count + smacc_pkg::RES_CNT_W'(pend);
  assign s_tready  = !clearing &&
                     (occupancy < smacc_pkg::RES_CNT_W'(smacc_pkg::RES_DEPTH));

  // clear sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    sr_eff = mono1 ? sl1 : sr1;
    delta_next.left  = smacc_pkg::scale(sl1, vl1, eight1);
    delta_next.right = smacc_pkg::scale(sr_eff, vr1, eight1);
    if (wr2 && (addr2 == addr1)) begin
      base_next = wr_val;
    end else if (lw_v && (lw_addr == addr1)) begin
      base_next = lw_data;
    end else begin
      base_next = rd_data;
    end
  end

  always_comb begin
    wr2 = v2 && inr2;
    if (op2 == smacc_pkg::OP_DRAIN) begin
      wr_val = '0;
    end else begin
      wr_val.left  = base2.left + delta2.left;
      wr_val.right = base2.right + delta2.right;
    end
    push = v2 && (op2 == smacc_pkg::OP_DRAIN);
    if (inr2) begin
      push_data.out_left  = smacc_pkg::saturate(base2.left);
      push_data.out_right = smacc_pkg::saturate(base2.right);
    end else begin
      push_data = '0;
    end
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = wr2;
      mem_waddr = addr2;
      mem_wdata = wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      lw_v <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      lw_v <= wr2;
    end
    op1     <= s_tuser;
    inr1    <= in_range;
    addr1   <= in_addr;
    sl1     <= s_tdata[25:10];
    sr1     <= s_tdata[41:26];
    eight1  <= s_tdata[42];
    mono1   <= s_tdata[43];
    vl1     <= s_tdata[59:44];
    vr1     <= s_tdata[75:60];
    op2     <= op1;
    inr2    <= inr1;
    addr2   <= addr1;
    base2   <= base_next;
    delta2  <= delta_next;
    lw_addr <= addr2;
    lw_data <= wr_val;
  end

  smacc_buffer #(
    .DEPTH (BUF_FRAMES),
    .AW    (AW)
  ) u_buffer (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (accept && in_range),
    .rd_addr (in_addr),
    .rd_data (rd_data)
  );

  smacc_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .count     (res_count)
  );

  assert property (@(posedge clk) disable iff (rst) clearing |-> !s_tready)
    else $error("transfer accepted during buffer clear");

  assert property (@(posedge clk) disable iff (rst)
    occupancy <= smacc_pkg::RES_CNT_W'(smacc_pkg::RES_DEPTH))
    else $error("result queue plus in-flight drains exceed capacity");

  assert property (@(posedge clk) disable iff (rst)
    (push && !inr2) |-> (push_data == '0))
    else $error("out-of-range drain returned nonzero data");

  assert property (@(posedge clk) disable iff (rst)
    clearing |-> !v1 && !v2)
    else $error("item in flight during buffer clear");

endmodule

[tb/sv/stereo_mix_accumulator_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_mix_accumulator_top_tb
// Self-checking bench for the stereo mix accumulator.
// ----------------------------------------------------------------------------
// Drives mix and drain transfers on the input stream and keeps its own copy of
// the stereo buffer. Each accepted drain queues the saturated frame it expects;
// each output transfer is checked against the oldest entry. Covers field
// extremes, 8-bit and mono sources, 32-bit wrap, same-frame bursts, random
// traffic with idle bursts on both sides, a long output hold-off and full rate.
// ----------------------------------------------------------------------------
module stereo_mix_accumulator_top_tb;

  localparam int FRAMES      = smacc_pkg::BUF_FRAMES_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTS  = 100;

  typedef struct {
    logic                                  op;
    logic [smacc_pkg::POS_W-1:0]           frame;
    logic signed [smacc_pkg::SAMPLE_W-1:0] smp_l;
    logic signed [smacc_pkg::SAMPLE_W-1:0] smp_r;
    logic                                  eight_bit;
    logic                                  mono;
    logic [smacc_pkg::SAMPLE_W-1:0]        vol_l;
    logic [smacc_pkg::SAMPLE_W-1:0]        vol_r;
  } acc_op_t;

  logic                              clk;
  logic                              rst;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [smacc_pkg::IN_TDATA_W-1:0]  s_tdata;
  logic                              s_tuser;
  logic                              m_tvalid;
  logic                              m_tready;
  logic [smacc_pkg::OUT_TDATA_W-1:0] m_tdata;

  logic [smacc_pkg::ACC_W-1:0] buf_left  [FRAMES];
  logic [smacc_pkg::ACC_W-1:0] buf_right [FRAMES];
  smacc_pkg::result_t          drain_q[$];

  bit idle_en   = 1'b1;
  bit hold_req  = 1'b0;
  int hold_left = 0;
  int err_cnt   = 0;
  int sent_cnt  = 0;
  int drain_cnt = 0;
  int cycle_cnt = 0;

  stereo_mix_accumulator_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---- prediction ----------------------------------------------------------

  function automatic logic [smacc_pkg::ACC_W-1:0] scaled_gain(
      input logic signed [smacc_pkg::SAMPLE_W-1:0] smp,
      input logic [smacc_pkg::SAMPLE_W-1:0] vol,
      input logic eight_bit);
    logic signed [47:0] prod;
    prod = 48'(smp) * 48'($signed({1'b0, vol}));
    prod = prod >>> (eight_bit ? smacc_pkg::SHIFT_8BIT : smacc_pkg::SHIFT_16BIT);
    return prod[smacc_pkg::ACC_W-1:0];
  endfunction

  function automatic logic [smacc_pkg::SAMPLE_W-1:0] clip16(
      input logic [smacc_pkg::ACC_W-1:0] w);
    logic signed [smacc_pkg::ACC_W-1:0] v;
    v = w;
    if (v > smacc_pkg::SAT_MAX) return smacc_pkg::SAT_MAX;
    if (v < smacc_pkg::SAT_MIN) return smacc_pkg::SAT_MIN;
    return v[smacc_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic apply_to_buffer(input acc_op_t a);
    logic signed [smacc_pkg::SAMPLE_W-1:0] src_r;
    smacc_pkg::result_t                    r;
    src_r = a.mono ? a.smp_l : a.smp_r;
    if (a.op == smacc_pkg::OP_MIX) begin
      if (a.frame < FRAMES) begin
        buf_left[a.frame]  = buf_left[a.frame] + scaled_gain(a.smp_l, a.vol_l, a.eight_bit);
        buf_right[a.frame] = buf_right[a.frame] + scaled_gain(src_r, a.vol_r, a.eight_bit);
      end
    end else begin
      r = '0;
      if (a.frame < FRAMES) begin
        r.out_left         = clip16(buf_left[a.frame]);
        r.out_right        = clip16(buf_right[a.frame]);
        buf_left[a.frame]  = '0;
        buf_right[a.frame] = '0;
      end
      drain_q.push_back(r);
    end
  endtask

  // ---- stimulus helpers ----------------------------------------------------

  function automatic acc_op_t make_op(input logic op,
                                      input logic [smacc_pkg::POS_W-1:0] frame,
                                      input logic [smacc_pkg::SAMPLE_W-1:0] sl,
                                      input logic [smacc_pkg::SAMPLE_W-1:0] sr,
                                      input logic eight_bit, input logic mono,
                                      input logic [smacc_pkg::SAMPLE_W-1:0] vl,
                                      input logic [smacc_pkg::SAMPLE_W-1:0] vr);
    acc_op_t a;
    a.op = op;         a.frame = frame;
    a.smp_l = sl;      a.smp_r = sr;
    a.eight_bit = eight_bit;
    a.mono = mono;
    a.vol_l = vl;      a.vol_r = vr;
    return a;
  endfunction

  function automatic logic [smacc_pkg::SAMPLE_W-1:0] draw_volume();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'h8000;
      2:       return smacc_pkg::SAMPLE_W'($urandom());
      default: return smacc_pkg::SAMPLE_W'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [smacc_pkg::SAMPLE_W-1:0] draw_sample(input logic eight_bit);
    logic signed [smacc_pkg::SAMPLE_W-1:0] s;
    if (eight_bit && $urandom_range(0, 7) != 0)
      s = smacc_pkg::SAMPLE_W'($signed(8'($urandom())));
    else s = smacc_pkg::SAMPLE_W'($urandom());
    return s;
  endfunction

  function automatic acc_op_t draw_op(input bit narrow, input int drain_pct);
    acc_op_t a;
    a.op        = ($urandom_range(0, 99) < drain_pct) ? smacc_pkg::OP_DRAIN
                                                      : smacc_pkg::OP_MIX;
    a.frame     = narrow ? smacc_pkg::POS_W'($urandom_range(0, 7))
                         : smacc_pkg::POS_W'($urandom());
    a.eight_bit = 1'($urandom_range(0, 1));
    a.mono      = ($urandom_range(0, 3) == 0);
    a.smp_l     = draw_sample(a.eight_bit);
    a.smp_r     = draw_sample(a.eight_bit);
    a.vol_l     = draw_volume();
    a.vol_r     = draw_volume();
    return a;
  endfunction

  task automatic send_op(input acc_op_t a);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, a.vol_r, a.vol_l, a.mono, a.eight_bit, a.smp_r, a.smp_l, a.frame};
    s_tuser  <= a.op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_to_buffer(a);
    sent_cnt++;
  endtask

  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (drain_q.size() != 0) @(posedge clk);
  endtask

  // ---- checking ------------------------------------------------------------

  task automatic report_mismatch(input string what,
                                 input logic [smacc_pkg::SAMPLE_W-1:0] got,
                                 input logic [smacc_pkg::SAMPLE_W-1:0] want);
    if (err_cnt < MAX_PRINTS)
      $display("%0t ERROR %s: got %h, want %h", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic check_drain(input logic [smacc_pkg::OUT_TDATA_W-1:0] data);
    smacc_pkg::result_t want;
    if (drain_q.size() == 0) begin
      report_mismatch("transfer with no drain pending", data[15:0], data[31:16]);
      return;
    end
    want = drain_q.pop_front();
    if (data[15:0] !== want.out_left) report_mismatch("out_left", data[15:0], want.out_left);
    if (data[31:16] !== want.out_right)
      report_mismatch("out_right", data[31:16], want.out_right);
    drain_cnt++;
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) check_drain(m_tdata);
      if (stall_left > 0) stall_left--;
      else if (idle_en && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 17);
      m_tready <= (stall_left == 0) && (hold_left == 0) && !rst;
    end
  end

  initial begin : hold_timer
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (hold_req) begin
        hold_left <= HOLD_CYCLES;
        hold_req  <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // ---- tests ---------------------------------------------------------------

  task automatic test_field_extremes();
    send_op(make_op(smacc_pkg::OP_DRAIN, 10'd0,    16'h0000, 16'h0000, 1'b0, 1'b0,
                    16'h0000, 16'h0000));
    send_op(make_op(smacc_pkg::OP_DRAIN, 10'd1023, 16'hffff, 16'hffff, 1'b1, 1'b1,
                    16'hffff, 16'hffff));
    send_op(make_op(smacc_pkg::OP_MIX,   10'd0,    16'h7fff, 16'h8000, 1'b0, 1'b0,
                    16'h8000, 16'h8000));
    send_op(make_op(smacc_pkg::OP_DRAIN, 10'd0,    16'h0000, 16'h0000, 1'b0, 1'b0,
                    16'h0000, 16'h0000));
    send_op(make_op(smacc_pkg::OP_MIX,   10'd1023, 16'h8000, 16'h7fff, 1'b0, 1'b0,
                    16'hffff, 16'hffff));
    send_op(make_op(smacc_pkg::OP_DRAIN, 10'd1023, 16'h0000, 16'h0000, 1'b0, 1'b0,
                    16'h0000, 16'h0000));
    // 8-bit source, in range and full 16-bit values
    send_op(make_op(smacc_pkg::OP_MIX,   10'd1,    16'h007f, 16'hff80, 1'b1, 1'b0,
                    16'h8000, 16'h8000));
    send_op(make_op(smacc_pkg::OP_MIX,   10'd1,    16'h8000, 16'h7fff, 1'b1, 1'b0,
                    16'h0001, 16'h0001));
    send_op(make_op(smacc_pkg::OP_DRAIN, 10'd1,    16'h0000, 16'h0000, 1'b1, 1'b0,
                    16'h0000, 16'h0000));
    // mono: right sample must be ignored
    send_op(make_op(smacc_pkg::OP_MIX,   10'd2,    16'hfc18, 16'h3039, 1'b0, 1'b1,
                    16'h4000, 16'h0000));
    send_op(make_op(smacc_pkg::OP_MIX,   10'd2,    16'hffff, 16'h7fff, 1'b0, 1'b1,
                    16'h0001, 16'h0001));
    send_op(make_op(smacc_pkg::OP_DRAIN, 10'd2,    16'h0000, 16'h0000, 1'b0, 1'b0,
                    16'h0000, 16'h0000));
    // zero volume, then floor rounding of a small negative product
    send_op(make_op(smacc_pkg::OP_MIX,   10'd3,    16'h8000, 16'h7fff, 1'b0, 1'b0,
                    16'h0000, 16'h0000));
    send_op(make_op(smacc_pkg::OP_MIX,   10'd3,    16'hffff, 16'hffff, 1'b0, 1'b0,
                    16'hffff, 16'h8001));
    send_op(make_op(smacc_pkg::OP_DRAIN, 10'd3,    16'h0000, 16'h0000, 1'b0, 1'b0,
                    16'h0000, 16'h0000));
    send_op(make_op(smacc_pkg::OP_DRAIN, 10'd3,    16'h0000, 16'h0000, 1'b0, 1'b0,
                    16'h0000, 16'h0000));
    // alternating bit patterns on every field
    send_op(make_op(smacc_pkg::OP_MIX,   10'h155,  16'h5555, 16'haaaa, 1'b0, 1'b0,
                    16'haaaa, 16'h5555));
    send_op(make_op(smacc_pkg::OP_MIX,   10'h155,  16'haaaa, 16'h5555, 1'b1, 1'b0,
                    16'h5555, 16'haaaa));
    send_op(make_op(smacc_pkg::OP_DRAIN, 10'h155,  16'h0000, 16'h0000, 1'b0, 1'b0,
                    16'h0000, 16'h0000));
    send_op(make_op(smacc_pkg::OP_MIX,   10'h2aa,  16'h0123, 16'hfedc, 1'b1, 1'b1,
                    16'h7fff, 16'h8000));
    send_op(make_op(smacc_pkg::OP_DRAIN, 10'h2aa,  16'h0000, 16'h0000, 1'b0, 1'b0,
                    16'h0000, 16'h0000));
  endtask

  // 140 full-scale adds push each channel past 2^31 so the word wraps
  task automatic test_accumulator_wrap();
    repeat (140)
      send_op(make_op(smacc_pkg::OP_MIX, 10'd5, 16'h7fff, 16'h8000, 1'b1, 1'b0,
                      16'hffff, 16'hffff));
    send_op(make_op(smacc_pkg::OP_DRAIN, 10'd5, 16'h0000, 16'h0000, 1'b0, 1'b0,
                    16'h0000, 16'h0000));
  endtask

  task automatic test_random_traffic();
    for (int seg = 0; seg < 10; seg++) begin
      for (int n = 0; n < 100; n++)
        send_op(draw_op(seg % 3 != 2, 20 + 10 * (seg % 5)));
    end
  endtask

  task automatic test_output_hold_off();
    idle_en  <= 1'b0;
    hold_req <= 1'b1;
    for (int n = 0; n < 120; n++) send_op(draw_op(1'b1, 50));
    wait_results_done();
    idle_en <= 1'b1;
  endtask

  task automatic test_pause_for_results();
    for (int round = 0; round < 4; round++) begin
      for (int n = 0; n < 40; n++) send_op(draw_op(round[0], 40));
      wait_results_done();
    end
  endtask

  task automatic test_full_rate();
    idle_en <= 1'b0;
    for (int n = 0; n < 250; n++) send_op(draw_op(n < 150, 35));
  endtask

  initial begin : stimulus
    foreach (buf_left[i]) begin
      buf_left[i]  = '0;
      buf_right[i] = '0;
    end
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = smacc_pkg::OP_MIX;
    m_tready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_accumulator_wrap();
    test_random_traffic();
    test_output_hold_off();
    test_pause_for_results();
    test_full_rate();

    wait_results_done();
    repeat (16) @(posedge clk);
    $display("Sent %0d mix/drain transfers, checked %0d drained frames, %0d mismatches.",
             sent_cnt, drain_cnt, err_cnt);
    $display("Covered extremes, 8-bit/mono, 32-bit wrap, output hold-off and full rate.");
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
